FILE: rtl/limit_order_book_matcher_unit_macros.svh
// Assertion macros used by the order book matcher datapath
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LOBM_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LOBM_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LOBM_CHECK(lbl, cond, msg)
`define LOBM_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/lobm_pkg.sv
// Types, constants and helpers for the order book matcher
`default_nettype none
package lobm_pkg;

  localparam int ID_W        = 10;
  localparam int PRICE_W     = 10;
  localparam int QTY_W       = 32;
  localparam int ORDER_SLOTS = 1 << ID_W;
  localparam int PRICE_TICKS = 1 << PRICE_W;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int IDW_W       = ID_W - BIT_W;
  localparam int PW_W        = PRICE_W - BIT_W;
  localparam int SUM_W       = PRICE_TICKS / WORD_W;
  localparam int LV_W        = PRICE_W + 1;
  localparam int OCCA_W      = PW_W + 1;
  localparam int MAX_FILLS   = 63;
  localparam int FILL_W      = 6;
  localparam int RES_DEPTH   = 64;
  localparam int RES_AW      = 6;
  localparam int RES_CW      = RES_AW + 1;
  localparam int KIND_W      = 3;
  localparam int CMD_W       = 2;
  localparam int SPR_W       = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD, CMD_CANCEL, CMD_MATCH, CMD_NONE
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRADE, KIND_ADDED, KIND_ADD_REJ, KIND_CANCELLED,
    KIND_CANCEL_NF, KIND_MATCH_DONE, KIND_FILL_LIMIT
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_CAN_RD, ST_CAN_CHK, ST_UL_RD, ST_UL_WR,
    ST_M_BEST, ST_M_LVL, ST_M_SLOT, ST_M_FILL, ST_M_DONE,
    ST_BB_RD, ST_BA_RD, ST_SUMM, ST_D_RD, ST_D_LD
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ADD_RD, OP_ADD_WR, OP_CAN_RD, OP_CAN_CHK, OP_UL_RD,
    OP_UL_WR, OP_M_BEST, OP_M_LVL, OP_M_SLOT, OP_M_FILL, OP_M_DONE,
    OP_BB_RD, OP_BA_RD, OP_SUMM, OP_D_RD, OP_D_LD
  } op_t;

  typedef struct packed {
    logic add_rej;
    logic not_live;
    logic is_cancel;
    logic m_stop;
    logic lvl_stop;
    logic exhaust;
    logic out_busy;
    logic last_res;
  } st_t;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } info_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    buy_id;
    logic [ID_W-1:0]    sell_id;
    logic [PRICE_W-1:0] tprice;
    logic [QTY_W-1:0]   tqty;
    logic [QTY_W-1:0]   lqty;
  } res_t;

  // highest set bit
  function automatic logic [BIT_W-1:0] msb_idx(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // lowest set bit
  function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lobm_ctrl.sv
// Sequencer for the order book: walks each request through its memory steps
`default_nettype none
module lobm_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [lobm_pkg::CMD_W-1:0] in_cmd,
  input  wire lobm_pkg::st_t             st,
  output lobm_pkg::op_t                  op,
  output logic                           in_stall
);
  import lobm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op = OP_LOAD;
          case (cmd_t'(in_cmd))
            CMD_ADD:    state_nxt = ST_ADD_RD;
            CMD_CANCEL: state_nxt = ST_CAN_RD;
            CMD_MATCH:  state_nxt = ST_M_BEST;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        op = OP_ADD_RD;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        op = OP_ADD_WR;
        state_nxt = ST_BB_RD;
      end
      ST_CAN_RD: begin
        op = OP_CAN_RD;
        state_nxt = ST_CAN_CHK;
      end
      ST_CAN_CHK: begin
        op = OP_CAN_CHK;
        state_nxt = st.not_live ? ST_BB_RD : ST_UL_RD;
      end
      ST_UL_RD: begin
        op = OP_UL_RD;
        state_nxt = ST_UL_WR;
      end
      ST_UL_WR: begin
        op = OP_UL_WR;
        state_nxt = st.is_cancel ? ST_BB_RD : ST_M_BEST;
      end
      ST_M_BEST: begin
        op = OP_M_BEST;
        state_nxt = st.m_stop ? ST_M_DONE : ST_M_LVL;
      end
      ST_M_LVL: begin
        op = OP_M_LVL;
        state_nxt = st.lvl_stop ? ST_M_DONE : ST_M_SLOT;
      end
      ST_M_SLOT: begin
        op = OP_M_SLOT;
        state_nxt = ST_M_FILL;
      end
      ST_M_FILL: begin
        op = OP_M_FILL;
        state_nxt = st.exhaust ? ST_UL_RD : ST_M_BEST;
      end
      ST_M_DONE: begin
        op = OP_M_DONE;
        state_nxt = ST_BB_RD;
      end
      ST_BB_RD: begin
        op = OP_BB_RD;
        state_nxt = ST_BA_RD;
      end
      ST_BA_RD: begin
        op = OP_BA_RD;
        state_nxt = ST_SUMM;
      end
      ST_SUMM: begin
        op = OP_SUMM;
        state_nxt = ST_D_RD;
      end
      ST_D_RD: begin
        if (!st.out_busy) begin
          op = OP_D_RD;
          state_nxt = ST_D_LD;
        end
      end
      ST_D_LD: begin
        op = OP_D_LD;
        state_nxt = st.last_res ? ST_IDLE : ST_D_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/lobm_dp.sv
// Datapath of the order book: slot, level and bitmap memories, result buffer
`default_nettype none
`include "limit_order_book_matcher_unit_macros.svh"
module lobm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lobm_pkg::op_t                 op,
  input  wire logic [lobm_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic                          in_side,
  input  wire logic                          in_is_market,
  input  wire logic [lobm_pkg::ID_W-1:0]     in_order_id,
  input  wire logic [lobm_pkg::PRICE_W-1:0]  in_price,
  input  wire logic [lobm_pkg::QTY_W-1:0]    in_quantity,
  input  wire logic                          out_stall,
  output lobm_pkg::st_t                      st,
  output logic                               out_valid,
  output logic [lobm_pkg::KIND_W-1:0]        out_kind,
  output logic [lobm_pkg::ID_W-1:0]          out_buy_id,
  output logic [lobm_pkg::ID_W-1:0]          out_sell_id,
  output logic [lobm_pkg::PRICE_W-1:0]       out_trade_price,
  output logic [lobm_pkg::QTY_W-1:0]         out_trade_qty,
  output logic [lobm_pkg::QTY_W-1:0]         out_left_qty,
  output logic [lobm_pkg::PRICE_W-1:0]       out_best_bid,
  output logic                               out_bid_valid,
  output logic [lobm_pkg::PRICE_W-1:0]       out_best_ask,
  output logic                               out_ask_valid,
  output logic signed [lobm_pkg::SPR_W-1:0]  out_spread_ticks,
  output logic                               out_last
);
  import lobm_pkg::*;

  // memories
  logic [WORD_W-1:0]  live_mem [2**IDW_W];
  logic [WORD_W-1:0]  occ_mem  [2**OCCA_W];
  info_t              info_mem [ORDER_SLOTS];
  logic [ID_W-1:0]    next_mem [ORDER_SLOTS];
  logic [ID_W-1:0]    prev_mem [ORDER_SLOTS];
  logic [ID_W-1:0]    head_mem [2**LV_W];
  logic [ID_W-1:0]    tail_mem [2**LV_W];
  res_t               res_mem  [RES_DEPTH];

  // row valid bits: a word not yet written reads as zero
  logic [2**IDW_W-1:0]  live_vld_r;
  logic [2**OCCA_W-1:0] occ_sum_r;

  // request registers
  cmd_t               cmd_r;
  logic               side_r, mkt_r, hit_r;
  logic [ID_W-1:0]    id_r, r_r, u_id_r, u_next_r, u_prev_r;
  logic [PRICE_W-1:0] price_r, p_r, u_price_r, bb_r, ba_r;
  logic               u_side_r, bv_r, av_r;
  logic [QTY_W-1:0]   qty_r, left_r;
  logic [FILL_W-1:0]  fills_r;
  logic [PW_W-1:0]    widx_r;
  logic [RES_CW-1:0]  wr_ptr_r;
  logic [RES_AW-1:0]  rd_ptr_r;
  logic               out_valid_r;

  // read data
  logic [WORD_W-1:0]  live_rd_r, occ_rd_r;
  logic               live_rv_r, occ_rv_r;
  info_t              info_rd_r;
  logic [ID_W-1:0]    next_rd_r, prev_rd_r, head_rd_r, tail_rd_r;
  res_t               res_rd_r;

  // ports
  logic               live_re, live_we, occ_re, occ_we, info_re, info_we;
  logic               next_re, next_we, prev_re, prev_we;
  logic               head_re, head_we, tail_re, tail_we, res_re, res_we;
  logic [IDW_W-1:0]   live_ra, live_wa;
  logic [WORD_W-1:0]  live_wd, occ_wd;
  logic [OCCA_W-1:0]  occ_ra, occ_wa;
  logic [ID_W-1:0]    info_ra, info_wa, next_ra, next_wa, prev_ra, prev_wa;
  logic [ID_W-1:0]    next_wd, prev_wd, head_wd, tail_wd;
  info_t              info_wd;
  logic [LV_W-1:0]    head_ra, head_wa, tail_ra, tail_wa;
  res_t               res_wd;

  logic               opp;
  logic [LV_W-1:0]    lv_in, u_lv;
  logic [WORD_W-1:0]  live_eff, occ_eff, id_bit, p_bit, u_id_bit, u_p_bit;
  logic [PW_W-1:0]    bid_w, ask_w, opp_w;
  logic [PRICE_W-1:0] p_best;
  logic               no_cross, fills_max, is_head, is_tail;
  logic [QTY_W-1:0]   rest_q, fill_q;

  assign opp      = ~side_r;
  assign lv_in    = {side_r, price_r};
  assign u_lv     = {u_side_r, u_price_r};
  assign live_eff = live_rv_r ? live_rd_r : '0;
  assign occ_eff  = occ_rv_r ? occ_rd_r : '0;
  assign id_bit   = WORD_W'(1) << id_r[BIT_W-1:0];
  assign p_bit    = WORD_W'(1) << price_r[BIT_W-1:0];
  assign u_id_bit = WORD_W'(1) << u_id_r[BIT_W-1:0];
  assign u_p_bit  = WORD_W'(1) << u_price_r[BIT_W-1:0];
  assign bid_w    = PW_W'(msb_idx(WORD_W'(occ_sum_r[SUM_W-1:0])));
  assign ask_w    = PW_W'(lsb_idx(WORD_W'(occ_sum_r[2*SUM_W-1:SUM_W])));
  assign opp_w    = opp ? ask_w : bid_w;
  assign p_best   = {widx_r, opp ? lsb_idx(occ_eff) : msb_idx(occ_eff)};
  assign no_cross = !mkt_r && (side_r ? (price_r > p_best) : (price_r < p_best));
  assign fills_max = fills_r >= FILL_W'(MAX_FILLS);
  assign is_head  = head_rd_r == u_id_r;
  assign is_tail  = tail_rd_r == u_id_r;
  assign fill_q   = (left_r < info_rd_r.qty) ? left_r : info_rd_r.qty;
  assign rest_q   = info_rd_r.qty - fill_q;

  always_comb begin
    st           = '0;
    st.add_rej   = (|(live_eff & id_bit)) || (qty_r == '0);
    st.not_live  = ~|(live_eff & id_bit);
    st.is_cancel = cmd_r == CMD_CANCEL;
    st.m_stop    = (left_r == '0) ||
                   (opp ? ~|occ_sum_r[2*SUM_W-1:SUM_W] : ~|occ_sum_r[SUM_W-1:0]);
    st.lvl_stop  = no_cross || fills_max;
    st.exhaust   = info_rd_r.qty <= left_r;
    st.out_busy  = out_valid_r;
    st.last_res  = {1'b0, rd_ptr_r} == (wr_ptr_r - RES_CW'(1));
  end

  always_comb begin
    live_re = 1'b0; live_we = 1'b0; live_ra = '0; live_wa = '0; live_wd = '0;
    occ_re  = 1'b0; occ_we  = 1'b0; occ_ra  = '0; occ_wa  = '0; occ_wd  = '0;
    info_re = 1'b0; info_we = 1'b0; info_ra = '0; info_wa = '0; info_wd = '0;
    next_re = 1'b0; next_we = 1'b0; next_ra = '0; next_wa = '0; next_wd = '0;
    prev_re = 1'b0; prev_we = 1'b0; prev_ra = '0; prev_wa = '0; prev_wd = '0;
    head_re = 1'b0; head_we = 1'b0; head_ra = '0; head_wa = '0; head_wd = '0;
    tail_re = 1'b0; tail_we = 1'b0; tail_ra = '0; tail_wa = '0; tail_wd = '0;
    res_re  = 1'b0; res_we  = 1'b0; res_wd  = '0;
    case (op)
      OP_ADD_RD: begin
        live_re = 1'b1; live_ra = id_r[ID_W-1:BIT_W];
        occ_re  = 1'b1; occ_ra  = {side_r, price_r[PRICE_W-1:BIT_W]};
        tail_re = 1'b1; tail_ra = lv_in;
      end
      OP_ADD_WR: begin
        res_we = 1'b1;
        if (st.add_rej) begin
          res_wd.kind = KIND_ADD_REJ;
        end else begin
          res_wd.kind = KIND_ADDED;
          live_we = 1'b1; live_wa = id_r[ID_W-1:BIT_W]; live_wd = live_eff | id_bit;
          info_we = 1'b1; info_wa = id_r;
          info_wd = '{side: side_r, price: price_r, qty: qty_r};
          tail_we = 1'b1; tail_wa = lv_in; tail_wd = id_r;
          if (|(occ_eff & p_bit)) begin
            prev_we = 1'b1; prev_wa = id_r; prev_wd = tail_rd_r;
            next_we = 1'b1; next_wa = tail_rd_r; next_wd = id_r;
          end else begin
            occ_we  = 1'b1; occ_wa = {side_r, price_r[PRICE_W-1:BIT_W]};
            occ_wd  = occ_eff | p_bit;
            head_we = 1'b1; head_wa = lv_in; head_wd = id_r;
          end
        end
      end
      OP_CAN_RD: begin
        live_re = 1'b1; live_ra = id_r[ID_W-1:BIT_W];
        info_re = 1'b1; info_ra = id_r;
        next_re = 1'b1; next_ra = id_r;
        prev_re = 1'b1; prev_ra = id_r;
      end
      OP_CAN_CHK: begin
        if (st.not_live) begin
          res_we = 1'b1; res_wd.kind = KIND_CANCEL_NF;
        end
      end
      OP_UL_RD: begin
        head_re = 1'b1; head_ra = u_lv;
        tail_re = 1'b1; tail_ra = u_lv;
        occ_re  = 1'b1; occ_ra  = {u_side_r, u_price_r[PRICE_W-1:BIT_W]};
        live_re = 1'b1; live_ra = u_id_r[ID_W-1:BIT_W];
      end
      OP_UL_WR: begin
        live_we = 1'b1; live_wa = u_id_r[ID_W-1:BIT_W]; live_wd = live_eff & ~u_id_bit;
        if (is_head && is_tail) begin
          occ_we = 1'b1; occ_wa = {u_side_r, u_price_r[PRICE_W-1:BIT_W]};
          occ_wd = occ_eff & ~u_p_bit;
        end else if (is_head) begin
          head_we = 1'b1; head_wa = u_lv; head_wd = u_next_r;
        end else if (is_tail) begin
          tail_we = 1'b1; tail_wa = u_lv; tail_wd = u_prev_r;
        end else begin
          next_we = 1'b1; next_wa = u_prev_r; next_wd = u_next_r;
          prev_we = 1'b1; prev_wa = u_next_r; prev_wd = u_prev_r;
        end
        if (cmd_r == CMD_CANCEL) begin
          res_we = 1'b1; res_wd.kind = KIND_CANCELLED;
        end
      end
      OP_M_BEST: begin
        occ_re = 1'b1; occ_ra = {opp, opp_w};
      end
      OP_M_LVL: begin
        head_re = 1'b1; head_ra = {opp, p_best};
      end
      OP_M_SLOT: begin
        info_re = 1'b1; info_ra = head_rd_r;
        next_re = 1'b1; next_ra = head_rd_r;
        prev_re = 1'b1; prev_ra = head_rd_r;
      end
      OP_M_FILL: begin
        info_we = 1'b1; info_wa = r_r;
        info_wd = '{side: info_rd_r.side, price: info_rd_r.price, qty: rest_q};
        res_we = 1'b1;
        res_wd.kind    = KIND_TRADE;
        res_wd.buy_id  = side_r ? r_r : id_r;
        res_wd.sell_id = side_r ? id_r : r_r;
        res_wd.tprice  = p_r;
        res_wd.tqty    = fill_q;
      end
      OP_M_DONE: begin
        res_we = 1'b1;
        res_wd.kind = hit_r ? KIND_FILL_LIMIT : KIND_MATCH_DONE;
        res_wd.lqty = left_r;
      end
      OP_BB_RD: begin
        occ_re = 1'b1; occ_ra = {1'b0, bid_w};
      end
      OP_BA_RD: begin
        occ_re = 1'b1; occ_ra = {1'b1, ask_w};
      end
      OP_D_RD: begin
        res_re = 1'b1;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    if (live_re) begin
      live_rd_r <= live_mem[live_ra];
      live_rv_r <= live_vld_r[live_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (occ_re) begin
      occ_rd_r <= occ_mem[occ_ra];
      occ_rv_r <= occ_sum_r[occ_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (info_re) info_rd_r <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_r <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_r <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd_r <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[wr_ptr_r[RES_AW-1:0]] <= res_wd;
    if (res_re) res_rd_r <= res_mem[rd_ptr_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_vld_r  <= '0;
      occ_sum_r   <= '0;
      out_valid_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fills_r     <= '0;
      hit_r       <= 1'b0;
    end else begin
      if (live_we) live_vld_r[live_wa] <= 1'b1;
      if (occ_we)  occ_sum_r[occ_wa]   <= |occ_wd;
      if (res_we)  wr_ptr_r <= wr_ptr_r + RES_CW'(1);
      if (op == OP_LOAD) begin
        wr_ptr_r <= '0;
        rd_ptr_r <= '0;
        fills_r  <= '0;
        hit_r    <= 1'b0;
      end
      if (op == OP_M_LVL && !no_cross && fills_max) hit_r <= 1'b1;
      if (op == OP_M_FILL) fills_r <= fills_r + FILL_W'(1);
      if (op == OP_D_LD) begin
        out_valid_r <= 1'b1;
        rd_ptr_r    <= rd_ptr_r + RES_AW'(1);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_r   <= cmd_t'(in_cmd);
        side_r  <= in_side;
        mkt_r   <= in_is_market;
        id_r    <= in_order_id;
        price_r <= in_price;
        qty_r   <= in_quantity;
        left_r  <= in_quantity;
      end
      OP_CAN_CHK: begin
        u_id_r    <= id_r;
        u_side_r  <= info_rd_r.side;
        u_price_r <= info_rd_r.price;
        u_next_r  <= next_rd_r;
        u_prev_r  <= prev_rd_r;
      end
      OP_M_BEST: widx_r <= opp_w;
      OP_M_LVL:  p_r <= p_best;
      OP_M_SLOT: r_r <= head_rd_r;
      OP_M_FILL: begin
        left_r    <= left_r - fill_q;
        u_id_r    <= r_r;
        u_side_r  <= info_rd_r.side;
        u_price_r <= info_rd_r.price;
        u_next_r  <= next_rd_r;
        u_prev_r  <= prev_rd_r;
      end
      OP_BA_RD: begin
        bv_r <= |occ_sum_r[SUM_W-1:0];
        bb_r <= (|occ_sum_r[SUM_W-1:0]) ? {bid_w, msb_idx(occ_eff)} : '0;
      end
      OP_SUMM: begin
        av_r <= |occ_sum_r[2*SUM_W-1:SUM_W];
        ba_r <= (|occ_sum_r[2*SUM_W-1:SUM_W]) ? {ask_w, lsb_idx(occ_eff)} : '0;
      end
      OP_D_LD: begin
        out_kind         <= res_rd_r.kind;
        out_buy_id       <= res_rd_r.buy_id;
        out_sell_id      <= res_rd_r.sell_id;
        out_trade_price  <= res_rd_r.tprice;
        out_trade_qty    <= res_rd_r.tqty;
        out_left_qty     <= res_rd_r.lqty;
        out_best_bid     <= bb_r;
        out_bid_valid    <= bv_r;
        out_best_ask     <= ba_r;
        out_ask_valid    <= av_r;
        out_spread_ticks <= (bv_r && av_r) ? (SPR_W'(ba_r) - SPR_W'(bb_r)) : '0;
        out_last         <= st.last_res;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  `LOBM_CHECK(a_res_bound, wr_ptr_r <= RES_CW'(RES_DEPTH), "result buffer overrun")
  `LOBM_CHECK(a_hit_at_limit, !hit_r || fills_r == FILL_W'(MAX_FILLS), "fill limit flag early")
  `LOBM_CHECK(a_unlink_live, (op != OP_UL_WR) || (|(live_eff & u_id_bit)), "unlink of dead slot")
  `LOBM_IMPLY(a_drain_loads, op == OP_D_LD, out_valid_r, "drained result not presented")

endmodule
`default_nettype wire

FILE: rtl/limit_order_book_matcher_unit.sv
// Top level of the price-time priority order book matcher
//
//  channel  direction  handshake            payload
//  in_      request    in_valid / in_stall  cmd, side, is_market, order_id, price, quantity
//  out_     result     out_valid/out_stall  kind, ids, trade, left, book top, spread, last
//
// The idle state takes a request; add then reads and writes the book, cancel reads and
// checks the slot and unlinks it if live, match reads level and slot and fills per trade,
// unlinks an emptied resting order, closes the walk, reads the book top, drains results.
// Reset clears the occupancy summaries and slot-live row valid bits; no clearing pass.
// The result register holds under out_stall; a request is taken while the last result waits.
`default_nettype none
module limit_order_book_matcher_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lobm_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic                          in_side,
  input  wire logic                          in_is_market,
  input  wire logic [lobm_pkg::ID_W-1:0]     in_order_id,
  input  wire logic [lobm_pkg::PRICE_W-1:0]  in_price,
  input  wire logic [lobm_pkg::QTY_W-1:0]    in_quantity,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lobm_pkg::KIND_W-1:0]        out_kind,
  output logic [lobm_pkg::ID_W-1:0]          out_buy_id,
  output logic [lobm_pkg::ID_W-1:0]          out_sell_id,
  output logic [lobm_pkg::PRICE_W-1:0]       out_trade_price,
  output logic [lobm_pkg::QTY_W-1:0]         out_trade_qty,
  output logic [lobm_pkg::QTY_W-1:0]         out_left_qty,
  output logic [lobm_pkg::PRICE_W-1:0]       out_best_bid,
  output logic                               out_bid_valid,
  output logic [lobm_pkg::PRICE_W-1:0]       out_best_ask,
  output logic                               out_ask_valid,
  output logic signed [lobm_pkg::SPR_W-1:0]  out_spread_ticks,
  output logic                               out_last
);
  import lobm_pkg::*;

  op_t op;
  st_t st;

  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .st       (st),
    .op       (op),
    .in_stall (in_stall)
  );

  lobm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_cmd           (in_cmd),
    .in_side          (in_side),
    .in_is_market     (in_is_market),
    .in_order_id      (in_order_id),
    .in_price         (in_price),
    .in_quantity      (in_quantity),
    .out_stall        (out_stall),
    .st               (st),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_buy_id       (out_buy_id),
    .out_sell_id      (out_sell_id),
    .out_trade_price  (out_trade_price),
    .out_trade_qty    (out_trade_qty),
    .out_left_qty     (out_left_qty),
    .out_best_bid     (out_best_bid),
    .out_bid_valid    (out_bid_valid),
    .out_best_ask     (out_best_ask),
    .out_ask_valid    (out_ask_valid),
    .out_spread_ticks (out_spread_ticks),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire
